FILE: rtl/core/rcs_pkg.sv
// shared constants, formats and tables of the raycast column setup core
package rcs_pkg;

  // screen and map geometry
  localparam int SCREEN_WIDTH = 640;
  localparam int MAP_BITS     = 8;

  // field widths
  localparam int COL_W      = 10;
  localparam int VIEW_W     = 9;
  localparam int POS_W      = 24;
  localparam int ANG_W      = 17;
  localparam int DIR_W      = 16;
  localparam int DIST_W     = 32;
  localparam int CELL_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_ANGLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_X      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_Y      = 2'd2;

  // angle arithmetic, degrees in Q.8
  localparam int FULL_TURN    = 360 * 256;
  localparam int QUARTER_TURN = 90 * 256;
  localparam int ANG_BIAS     = FULL_TURN - 30 * 256;
  localparam int COL_SCALE    = 60 * 256;
  localparam int PROD_W       = 24;
  localparam int COL_DIV      = SCREEN_WIDTH - 1;
  localparam int COL_SH       = 24;
  localparam int COL_RECIP    = (1 << COL_SH) / COL_DIV;
  localparam int SUM_W        = 25;
  localparam int TURN_SH      = 25;
  localparam int TURN_RECIP   = (1 << TURN_SH) / FULL_TURN;
  localparam int TQ_W         = 9;
  localparam int RES_W        = 15;

  // cordic
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_GAIN  = 652032874;
  localparam int CX_W         = 33;
  localparam int CZ_W         = 25;
  localparam int UNIT         = 16384;

  // reciprocal divider: 2^30 / magnitude
  localparam int MAG_W      = 15;
  localparam int DIV_Q_W    = 31;
  localparam int DIV_BPS    = 4;
  localparam int DIV_STAGES = (DIV_Q_W + DIV_BPS - 1) / DIV_BPS;

  // atan(2^-i) in degrees, Q.16
  function automatic logic signed [CZ_W-1:0] atan_lut(input int idx);
    logic signed [CZ_W-1:0] val;
    case (idx)
      0:       val = 25'sd2949120;
      1:       val = 25'sd1740967;
      2:       val = 25'sd919879;
      3:       val = 25'sd466945;
      4:       val = 25'sd234379;
      5:       val = 25'sd117304;
      6:       val = 25'sd58666;
      7:       val = 25'sd29335;
      8:       val = 25'sd14668;
      9:       val = 25'sd7334;
      10:      val = 25'sd3667;
      11:      val = 25'sd1834;
      12:      val = 25'sd917;
      13:      val = 25'sd458;
      14:      val = 25'sd229;
      15:      val = 25'sd115;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

FILE: rtl/core/rcs_div_pipe.sv
// pipelined restoring divider giving 2^30 / magnitude, four quotient bits per stage
module rcs_div_pipe (
  input  logic                        clk_i,
  input  logic                        adv_i,
  input  logic [rcs_pkg::MAG_W-1:0]   mag_i,
  output logic [rcs_pkg::DIV_Q_W-1:0] quot_o
);
  import rcs_pkg::*;

  logic [MAG_W-1:0]   rem_q [DIV_STAGES-1];
  logic [MAG_W-1:0]   mag_q [DIV_STAGES-1];
  logic [DIV_Q_W-1:0] quo_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [MAG_W-1:0]   rem_in;
    logic [MAG_W-1:0]   mag_in;
    logic [DIV_Q_W-1:0] quo_in;
    logic [MAG_W-1:0]   rem_d;
    logic [DIV_Q_W-1:0] quo_d;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign mag_in = mag_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign mag_in = mag_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    always_comb begin
      logic [MAG_W:0] t;
      int             b;
      rem_d = rem_in;
      quo_d = quo_in;
      for (int j = 0; j < DIV_BPS; j++) begin
        b = DIV_Q_W - 1 - DIV_BPS * k - j;
        if (b >= 0) begin
          // the dividend has its only set bit at the top
          t = {rem_d, (b == DIV_Q_W - 1)};
          if (t >= {1'b0, mag_in}) begin
            rem_d = MAG_W'(t - {1'b0, mag_in});
            quo_d = {quo_d[DIV_Q_W-2:0], 1'b1};
          end else begin
            rem_d = t[MAG_W-1:0];
            quo_d = {quo_d[DIV_Q_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        quo_q[k] <= quo_d;
      end
    end

    if (k < DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          rem_q[k] <= rem_d;
          mag_q[k] <= mag_in;
        end
      end
    end
  end

  assign quot_o = quo_q[DIV_STAGES-1];

endmodule

FILE: rtl/core/raycast_column_setup_core.sv
// top level of the raycast column setup core: angle, cordic, reciprocal and side distances
// One column is taken every cycle while the output is not stalled. The pipeline holds
// the angle reduction (eight stages of reciprocal multiplies), the quadrant split, the
// sixteen-stage cordic (one rotation per stage), the eight-stage reciprocal divider
// (four quotient bits per stage) and the delta and side distance stages. A stall on the
// output holds the whole pipeline, which then stalls the input. The view angle and
// position registers are read while items are in flight, so write them only while
// the core holds no item.
module raycast_column_setup_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rcs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rcs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           valid_i,
  output logic                           stall_o,
  input  logic [rcs_pkg::COL_W-1:0]      column_i,
  output logic                           valid_o,
  input  logic                           stall_i,
  output logic [rcs_pkg::ANG_W-1:0]      ray_angle_o,
  output logic signed [rcs_pkg::DIR_W-1:0] dir_x_o,
  output logic signed [rcs_pkg::DIR_W-1:0] dir_y_o,
  output logic [rcs_pkg::DIST_W-1:0]     delta_x_o,
  output logic [rcs_pkg::DIST_W-1:0]     delta_y_o,
  output logic                           step_neg_x_o,
  output logic                           step_neg_y_o,
  output logic [rcs_pkg::DIST_W-1:0]     side_x_o,
  output logic [rcs_pkg::DIST_W-1:0]     side_y_o,
  output logic [rcs_pkg::CELL_W-1:0]     cell_x_o,
  output logic [rcs_pkg::CELL_W-1:0]     cell_y_o
);
  import rcs_pkg::*;

  localparam int S_COL   = 1;
  localparam int S_MUL   = 2;
  localparam int S_EST   = 3;
  localparam int S_QUO   = 4;
  localparam int S_SUM   = 5;
  localparam int S_TMUL  = 6;
  localparam int S_TEST  = 7;
  localparam int S_ANG   = 8;
  localparam int S_QUAD  = 9;
  localparam int S_CORD  = S_QUAD + 1;
  localparam int S_DIR   = S_CORD + CORDIC_STEPS;
  localparam int S_DIVN  = S_DIR + DIV_STAGES;
  localparam int S_DELTA = S_DIVN + 1;
  localparam int S_SIDE  = S_DELTA + 1;
  localparam int NS      = S_SIDE;

  localparam logic [CELL_W-1:0] CELL_MASK = CELL_W'((1 << MAP_BITS) - 1);

  // configuration
  logic [VIEW_W-1:0] view_q;
  logic [POS_W-1:0]  pos_x_q, pos_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_q  <= '0;
      pos_x_q <= '0;
      pos_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VIEW_ANGLE: view_q  <= cfg_data_i[VIEW_W-1:0];
        CFG_POS_X:      pos_x_q <= cfg_data_i[POS_W-1:0];
        CFG_POS_Y:      pos_y_q <= cfg_data_i[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic          adv;
  logic [NS:1]   v_q;

  assign adv     = !(v_q[NS] && stall_i);
  assign stall_o = !adv;
  assign valid_o = v_q[NS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NS-1:1], valid_i};
    end
  end

  // column to angle offset: 60*256*col / (width-1) by reciprocal and one correction, then added to the view and wrapped
  logic [COL_W-1:0]      col_q [S_COL:S_EST];
  logic [2*PROD_W:0]     prodr_q;
  logic [PROD_W-1:0]     qe_q;
  logic [PROD_W-1:0]     quo_q;
  logic [SUM_W-1:0]      b_q [S_SUM:S_TEST];
  logic [SUM_W+TQ_W-1:0] br_q;
  logic [TQ_W-1:0]       tq_q;
  logic [ANG_W-1:0]      ang_q [S_ANG:NS];

  logic [PROD_W-1:0]     prod_m, prod_c;
  logic [PROD_W:0]       rem_c;
  logic [SUM_W-1:0]      diff_c;

  assign prod_m = PROD_W'(col_q[S_COL] * COL_SCALE);
  assign prod_c = PROD_W'(col_q[S_EST] * COL_SCALE);
  assign rem_c  = {1'b0, prod_c} - (PROD_W + 1)'(qe_q * COL_DIV);
  assign diff_c = b_q[S_TEST] - SUM_W'(tq_q * FULL_TURN);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      col_q[S_COL]   <= column_i;
      col_q[S_MUL]   <= col_q[S_COL];
      col_q[S_EST]   <= col_q[S_MUL];
      prodr_q        <= (2 * PROD_W + 1)'(prod_m) * (2 * PROD_W + 1)'(COL_RECIP);
      qe_q           <= prodr_q[COL_SH +: PROD_W];
      quo_q          <= (rem_c >= (PROD_W + 1)'(COL_DIV)) ? qe_q + 1'b1 : qe_q;
      // biased by a full turn less 30 degrees so the sum is never negative
      b_q[S_SUM]     <= (SUM_W'(view_q) << 8) + SUM_W'(ANG_BIAS) + SUM_W'(quo_q);
      b_q[S_TMUL]    <= b_q[S_SUM];
      b_q[S_TEST]    <= b_q[S_TMUL];
      br_q           <= (SUM_W + TQ_W)'(b_q[S_SUM]) * (SUM_W + TQ_W)'(TURN_RECIP);
      tq_q           <= br_q[TURN_SH +: TQ_W];
      ang_q[S_ANG]   <= (diff_c >= SUM_W'(FULL_TURN)) ? ANG_W'(diff_c - SUM_W'(FULL_TURN))
                                                      : ANG_W'(diff_c);
    end
  end

  for (genvar s = S_QUAD; s <= NS; s++) begin : g_ang
    always_ff @(posedge clk_i) begin
      if (adv) begin
        ang_q[s] <= ang_q[s-1];
      end
    end
  end

  // quadrant split
  logic [1:0]       quad_q [S_QUAD:S_DIR-1];
  logic             rz_q   [S_QUAD:S_DIR-1];
  logic [RES_W-1:0] res_q;
  logic [1:0]       quad_d;
  logic [ANG_W-1:0] res_d;

  always_comb begin
    if (ang_q[S_ANG] >= ANG_W'(3 * QUARTER_TURN)) begin
      quad_d = 2'd3;
      res_d  = ang_q[S_ANG] - ANG_W'(3 * QUARTER_TURN);
    end else if (ang_q[S_ANG] >= ANG_W'(2 * QUARTER_TURN)) begin
      quad_d = 2'd2;
      res_d  = ang_q[S_ANG] - ANG_W'(2 * QUARTER_TURN);
    end else if (ang_q[S_ANG] >= ANG_W'(QUARTER_TURN)) begin
      quad_d = 2'd1;
      res_d  = ang_q[S_ANG] - ANG_W'(QUARTER_TURN);
    end else begin
      quad_d = 2'd0;
      res_d  = ang_q[S_ANG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      quad_q[S_QUAD] <= quad_d;
      res_q          <= res_d[RES_W-1:0];
      rz_q[S_QUAD]   <= (res_d == '0);
    end
  end

  for (genvar s = S_CORD; s < S_DIR; s++) begin : g_quad
    always_ff @(posedge clk_i) begin
      if (adv) begin
        quad_q[s] <= quad_q[s-1];
        rz_q[s]   <= rz_q[s-1];
      end
    end
  end

  // cordic, one rotation per stage
  logic signed [CX_W-1:0] cx_q [CORDIC_STEPS];
  logic signed [CX_W-1:0] cy_q [CORDIC_STEPS];
  logic signed [CZ_W-1:0] cz_q [CORDIC_STEPS-1];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [CX_W-1:0] x_in, y_in, x_d, y_d;
    logic signed [CZ_W-1:0] z_in, z_d;

    if (i == 0) begin : g_init
      assign x_in = CX_W'(CORDIC_GAIN);
      assign y_in = '0;
      assign z_in = $signed({2'b00, res_q, 8'h00});
    end else begin : g_chain
      assign x_in = cx_q[i-1];
      assign y_in = cy_q[i-1];
      assign z_in = cz_q[i-1];
    end

    always_comb begin
      if (!z_in[CZ_W-1]) begin
        x_d = x_in - (y_in >>> i);
        y_d = y_in + (x_in >>> i);
        z_d = z_in - atan_lut(i);
      end else begin
        x_d = x_in + (y_in >>> i);
        y_d = y_in - (x_in >>> i);
        z_d = z_in + atan_lut(i);
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        cx_q[i] <= x_d;
        cy_q[i] <= y_d;
      end
    end

    if (i < CORDIC_STEPS - 1) begin : g_zc
      always_ff @(posedge clk_i) begin
        if (adv) begin
          cz_q[i] <= z_d;
        end
      end
    end
  end

  // round to Q1.14 and fold into the quadrant
  function automatic logic [RES_W-1:0] round_unit(input logic signed [CX_W-1:0] v);
    logic [CX_W:0]    r;
    logic [CX_W-16:0] t;
    r = v[CX_W-1] ? '0 : ((CX_W + 1)'(unsigned'(v)) + (CX_W + 1)'(32768));
    t = r[CX_W:16];
    return (t > (CX_W - 15)'(UNIT)) ? RES_W'(UNIT) : RES_W'(t);
  endfunction

  logic signed [DIR_W-1:0] dx_q [S_DIR:NS];
  logic signed [DIR_W-1:0] dy_q [S_DIR:NS];
  logic [RES_W-1:0]        cos_c, sin_c;
  logic signed [DIR_W-1:0] cp, cn, sp, sn;

  assign cos_c = rz_q[S_DIR-1] ? RES_W'(UNIT) : round_unit(cx_q[CORDIC_STEPS-1]);
  assign sin_c = rz_q[S_DIR-1] ? '0 : round_unit(cy_q[CORDIC_STEPS-1]);
  assign cp = $signed({1'b0, cos_c});
  assign sp = $signed({1'b0, sin_c});
  assign cn = -cp;
  assign sn = -sp;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      case (quad_q[S_DIR-1])
        2'd0: begin
          dx_q[S_DIR] <= cp;
          dy_q[S_DIR] <= sp;
        end
        2'd1: begin
          dx_q[S_DIR] <= sn;
          dy_q[S_DIR] <= cp;
        end
        2'd2: begin
          dx_q[S_DIR] <= cn;
          dy_q[S_DIR] <= sn;
        end
        default: begin
          dx_q[S_DIR] <= sp;
          dy_q[S_DIR] <= cn;
        end
      endcase
    end
  end

  for (genvar s = S_DIR + 1; s <= NS; s++) begin : g_dir
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dx_q[s] <= dx_q[s-1];
        dy_q[s] <= dy_q[s-1];
      end
    end
  end

  // reciprocal of each direction magnitude
  logic [DIR_W-1:0]   abs_x, abs_y;
  logic [DIV_Q_W-1:0] quot_x, quot_y;

  assign abs_x = dx_q[S_DIR][DIR_W-1] ? DIR_W'(-dx_q[S_DIR]) : DIR_W'(dx_q[S_DIR]);
  assign abs_y = dy_q[S_DIR][DIR_W-1] ? DIR_W'(-dy_q[S_DIR]) : DIR_W'(dy_q[S_DIR]);

  rcs_div_pipe u_div_x (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .mag_i  (abs_x[MAG_W-1:0]),
    .quot_o (quot_x)
  );

  rcs_div_pipe u_div_y (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .mag_i  (abs_y[MAG_W-1:0]),
    .quot_o (quot_y)
  );

  logic [DIST_W-1:0] dl_x_q [S_DELTA:NS];
  logic [DIST_W-1:0] dl_y_q [S_DELTA:NS];
  logic [DIST_W-1:0] sd_x_q, sd_y_q;

  // saturate where the component is zero
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dl_x_q[S_DELTA] <= (dx_q[S_DIVN] == '0) ? '1 : DIST_W'(quot_x);
      dl_y_q[S_DELTA] <= (dy_q[S_DIVN] == '0) ? '1 : DIST_W'(quot_y);
      dl_x_q[S_SIDE]  <= dl_x_q[S_DELTA];
      dl_y_q[S_SIDE]  <= dl_y_q[S_DELTA];
    end
  end

  // side distance: grid fraction toward the step direction times delta
  function automatic logic [DIST_W-1:0] side_dist(input logic [15:0] frac, input logic neg,
                                                  input logic [DIST_W-1:0] dl);
    logic [16:0]       f;
    logic [DIST_W+16:0] p;
    f = neg ? {1'b0, frac} : (17'h10000 - {1'b0, frac});
    p = (DIST_W + 17)'(f) * (DIST_W + 17)'(dl);
    return p[DIST_W+16] ? '1 : p[DIST_W+15:16];
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_x_q <= side_dist(pos_x_q[15:0], dx_q[S_DELTA][DIR_W-1], dl_x_q[S_DELTA]);
      sd_y_q <= side_dist(pos_y_q[15:0], dy_q[S_DELTA][DIR_W-1], dl_y_q[S_DELTA]);
    end
  end

  assign ray_angle_o  = ang_q[NS];
  assign dir_x_o      = dx_q[NS];
  assign dir_y_o      = dy_q[NS];
  assign delta_x_o    = dl_x_q[NS];
  assign delta_y_o    = dl_y_q[NS];
  assign step_neg_x_o = dx_q[NS][DIR_W-1];
  assign step_neg_y_o = dy_q[NS][DIR_W-1];
  assign side_x_o     = sd_x_q;
  assign side_y_o     = sd_y_q;
  assign cell_x_o     = pos_x_q[POS_W-1:16] & CELL_MASK;
  assign cell_y_o     = pos_y_q[POS_W-1:16] & CELL_MASK;

  // checks
  a_stall_only_on_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i))
    else $error("input stalled without a held item");

  a_angle_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (ray_angle_o < ANG_W'(FULL_TURN)))
    else $error("ray angle not wrapped");

  a_delta_sat_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((delta_x_o == '1) == (dir_x_o == '0)))
    else $error("x delta saturation mismatch");

  a_delta_sat_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((delta_y_o == '1) == (dir_y_o == '0)))
    else $error("y delta saturation mismatch");

endmodule
